/* rtl/core/bcei_pkg.sv */
package bcei_pkg;

  localparam int LAYERS     = 512;
  localparam int RECORDS    = 256;
  localparam int COUNT_BITS = 16;

  localparam int BIN_TOTAL = LAYERS * RECORDS;
  localparam int BIN_BITS  = (BIN_TOTAL > 1) ? $clog2(BIN_TOTAL) : 1;

  // root of count * 2^32 needs half the bits of the radicand, rounded up
  localparam int ROOT_W    = (COUNT_BITS + 33) / 2;
  localparam int STEP_BITS = $clog2(ROOT_W);

  localparam int ERR_W     = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = ERR_W + ROOT_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_CLEAR = 2'd0;
  localparam cmd_t CMD_COUNT = 2'd1;
  localparam cmd_t CMD_SCALE = 2'd2;

endpackage

/* rtl/core/bcei_sqrt.sv */
module bcei_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [bcei_pkg::COUNT_BITS-1:0] cnt,
  output logic                            done,
  output logic [bcei_pkg::ROOT_W-1:0]     root
);
  import bcei_pkg::*;

  logic [2*ROOT_W-1:0]  rad;
  logic [ROOT_W+1:0]    rem;
  logic [ROOT_W+1:0]    rem_sh;
  logic [ROOT_W+1:0]    trial;
  logic [ROOT_W+1:0]    rem_next;
  logic [ROOT_W-1:0]    root_next;
  logic [STEP_BITS-1:0] step;
  logic                 running;
  logic                 ge;

  // one root bit per cycle, two radicand bits brought down each step
  always_comb begin
    rem_sh    = {rem[ROOT_W-1:0], rad[2*ROOT_W-1 -: 2]};
    trial     = {root, 2'b01};
    ge        = (rem_sh >= trial);
    rem_next  = ge ? (rem_sh - trial) : rem_sh;
    root_next = {root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rad     <= (2*ROOT_W)'({cnt, 32'b0});
        rem     <= '0;
        root    <= '0;
        step    <= STEP_BITS'(ROOT_W - 1);
        running <= 1'b1;
      end else if (running) begin
        rad  <= {rad[2*ROOT_W-3:0], 2'b00};
        rem  <= rem_next;
        root <= root_next;
        if (step == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/bin_count_error_inflation.sv */
// bin-count error inflation
// a word is offered on cmd and the item fields with start high; it is taken
// at a rising edge where start is high and busy is low. busy stays high for
// the whole of one item.
// cmd clear zeros the bin table by sweeping one entry per cycle over all
// LAYERS*RECORDS entries (131072 as built). the same sweep runs straight
// after reset, so busy is high and no word is taken until it has ended.
// cmd count does one read-modify-write of the bin memory, with no result.
// cmd scale reads the bin, takes the square root on a dedicated add/compare
// unit one root bit per cycle, then does one multiply and raises done from
// ST_FIN; when the count is zero or the error is missing it skips the root
// and the multiply and goes from ST_USE straight to ST_FIN.
// the unused command code is taken and dropped without busy rising.
// a result is on scaled_error, missing_out, bin_count and saturated for
// exactly one cycle with done high; the receiver cannot stall it.
// no new word is taken until the last item is through, since one state
// machine with one root unit handles each item in turn.
module bin_count_error_inflation (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 cmd,
  input  logic [8:0]                 layer_index,
  input  logic [8:0]                 record_number,
  input  logic [7:0]                 qc_flag,
  input  logic [bcei_pkg::ERR_W-1:0] obs_error,
  input  logic                       error_missing,
  output logic                       done,
  output logic [bcei_pkg::ERR_W-1:0] scaled_error,
  output logic                       missing_out,
  output logic [15:0]                bin_count,
  output logic                       saturated
);
  import bcei_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_USE   = 3'd4;
  localparam logic [2:0] ST_ROOT  = 3'd5;
  localparam logic [2:0] ST_MUL   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]            state;
  logic [BIN_BITS-1:0]   clr_addr;

  // latched word
  cmd_t                  cmd_r;
  logic [8:0]            layer_r;
  logic [8:0]            rec_r;
  logic                  qc_zero;
  logic [ERR_W-1:0]      err_r;
  logic                  miss_r;

  logic [BIN_BITS-1:0]   idx;
  logic                  in_range;
  logic [31:0]           idx_full;
  logic                  range_ok;

  logic [COUNT_BITS-1:0] mem [BIN_TOTAL];
  logic [COUNT_BITS-1:0] rd_data;
  logic                  we;
  logic [BIN_BITS-1:0]   waddr;
  logic [COUNT_BITS-1:0] wdata;

  logic [COUNT_BITS-1:0] cnt_use;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  bypass;
  logic                  sqrt_go;
  logic                  sqrt_done;
  logic [ROOT_W-1:0]     root;
  logic [PROD_W-1:0]     prod;

  assign busy = (state != ST_IDLE);

  always_comb begin
    idx_full = 32'(layer_r) * 32'(RECORDS) + 32'(rec_r) - 32'd1;
    range_ok = (32'(layer_r) < 32'(LAYERS)) && (rec_r != 9'd0)
               && (32'(rec_r) <= 32'(RECORDS));
  end

  assign cnt_use = in_range ? rd_data : '0;

  // memory port: clearing sweep or count write-back
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rd_data + 1'b1;
    if (state == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (state == ST_USE && cmd_r == CMD_COUNT && in_range && qc_zero
                 && rd_data != COUNT_MAX) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[idx];
  end

  assign sqrt_go = (state == ST_USE) && (cmd_r == CMD_SCALE) && !miss_r
                   && (cnt_use != '0);

  bcei_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .go   (sqrt_go),
    .cnt  (cnt_use),
    .done (sqrt_done),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == BIN_BITS'(BIN_TOTAL - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cmd_r   <= cmd;
            layer_r <= layer_index;
            rec_r   <= record_number;
            qc_zero <= (qc_flag == 8'd0);
            err_r   <= obs_error;
            miss_r  <= error_missing;
            if (cmd == CMD_CLEAR) begin
              clr_addr <= '0;
              state    <= ST_CLEAR;
            end else if (cmd == CMD_COUNT || cmd == CMD_SCALE) begin
              state <= ST_ADDR;
            end
          end
        end
        ST_ADDR: begin
          idx      <= BIN_BITS'(idx_full);
          in_range <= range_ok;
          state    <= ST_READ;
        end
        ST_READ: begin
          state <= ST_USE;
        end
        ST_USE: begin
          cnt_r  <= cnt_use;
          bypass <= miss_r || (cnt_use == '0);
          if (cmd_r != CMD_SCALE) begin
            state <= ST_IDLE;
          end else if (sqrt_go) begin
            state <= ST_ROOT;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= PROD_W'(err_r) * PROD_W'(root);
          state <= ST_FIN;
        end
        ST_FIN: begin
          done        <= 1'b1;
          missing_out <= miss_r;
          bin_count   <= (32'(cnt_r) > 32'h0000_FFFF) ? 16'hFFFF : 16'(cnt_r);
          if (bypass) begin
            scaled_error <= err_r;
            saturated    <= 1'b0;
          end else if (prod[PROD_W-1:ERR_W+FRAC_BITS] != '0) begin
            scaled_error <= '1;
            saturated    <= 1'b1;
          end else begin
            scaled_error <= prod[ERR_W+FRAC_BITS-1:FRAC_BITS];
            saturated    <= 1'b0;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
